// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks share clk and arst_n of the including module.

// Property holds at every clock edge out of reset.
`define TZCT_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When ante holds, cons holds at the next clock edge.
`define TZCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tzct_pkg.sv =====
`timescale 1ns / 1ps

package tzct_pkg;

	// Touch panel height in pixels; zone bounds follow from it.
	localparam int SCREEN_HEIGHT = 480;
	localparam logic [12:0] ZONE_UPPER_END = 13'(SCREEN_HEIGHT / 3);
	localparam logic [12:0] ZONE_LOWER_START = 13'(2 * SCREEN_HEIGHT / 3);

	localparam int SEC_PER_MIN = 60;
	localparam logic [6:0] LIMIT_MINUTES = 7'd120;
	localparam logic [5:0] LIMIT_STEP = 6'd60;
	localparam logic [12:0] MIN_SET_SEC = 13'(SEC_PER_MIN);
	localparam logic [12:0] MAX_SET_SEC = 13'(120 * SEC_PER_MIN);

	localparam logic [6:0] DEFAULT_MIN_RST = 7'd25;
	localparam logic [5:0] STEP_MIN_RST = 6'd5;
	localparam logic [6:0] MAX_MIN_RST = 7'd120;
	localparam logic [12:0] SET_SEC_RST = 13'(25 * SEC_PER_MIN);

	// Request codes
	localparam logic [2:0] REQ_TICK = 3'd0;
	localparam logic [2:0] REQ_TOUCH = 3'd1;
	localparam logic [2:0] REQ_SET_MIN = 3'd2;
	localparam logic [2:0] REQ_RUN = 3'd3;
	localparam logic [2:0] REQ_DISMISS = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEFAULT_MIN = 2'd0;
	localparam logic [1:0] CFG_STEP_MIN = 2'd1;
	localparam logic [1:0] CFG_MAX_MIN = 2'd2;

	localparam int CFG_DATA_W = 7;
	localparam int CFG_INDEX_W = 2;

	typedef struct packed {
		logic [2:0] req_type;
		logic [8:0] touch_y;
		logic [7:0] minutes;
		logic run_flag;
	} in_t;

	typedef struct packed {
		logic [12:0] remaining_seconds;
		logic [12:0] set_seconds;
		logic running;
		logic paused;
		logic expired;
		logic alarm;
	} out_t;

	// Configuration, already clamped to its legal range
	typedef struct packed {
		logic [6:0] default_min;
		logic [5:0] step_min;
		logic [6:0] max_min;
	} cfg_t;

	typedef struct packed {
		logic [12:0] set_time;
		logic [12:0] time_left;
		logic is_running;
		logic alarm_on;
	} state_t;

	// m * 60 as (m << 6) - (m << 2); m never exceeds 127
	function automatic logic [12:0] min_to_sec(input logic [6:0] m);
		logic [12:0] mw;
		mw = {6'd0, m};
		return (mw << 6) - (mw << 2);
	endfunction

endpackage

// ===== design/tzct_cfg.sv =====
`timescale 1ns / 1ps

module tzct_cfg
	import tzct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;
	logic [6:0] min_clamped;
	logic [5:0] step_clamped;

	// zero acts as one, values above the limit act as the limit
	always_comb begin
		if (cfg_data == '0) begin
			min_clamped = 7'd1;
		end else if (cfg_data > LIMIT_MINUTES) begin
			min_clamped = LIMIT_MINUTES;
		end else begin
			min_clamped = cfg_data;
		end
		if (cfg_data[5:0] == '0) begin
			step_clamped = 6'd1;
		end else if (cfg_data[5:0] > LIMIT_STEP) begin
			step_clamped = LIMIT_STEP;
		end else begin
			step_clamped = cfg_data[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_min <= DEFAULT_MIN_RST;
			cfg_q.step_min <= STEP_MIN_RST;
			cfg_q.max_min <= MAX_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEFAULT_MIN: cfg_q.default_min <= min_clamped;
				CFG_STEP_MIN: cfg_q.step_min <= step_clamped;
				CFG_MAX_MIN: cfg_q.max_min <= min_clamped;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/tzct_next.sv =====
`timescale 1ns / 1ps

module tzct_next
	import tzct_pkg::*;
(
	input state_t cur,
	input in_t req,
	input cfg_t cfg,
	output state_t nxt,
	output out_t res
);

	logic [12:0] step_sec;
	logic [12:0] max_sec;
	logic [12:0] dflt_sec;
	logic [13:0] sum_up;
	logic [12:0] floor_dn;
	logic [12:0] y_ext;
	logic [6:0] set_min;
	logic expired;

	assign step_sec = min_to_sec({1'b0, cfg.step_min});
	assign max_sec = min_to_sec(cfg.max_min);
	assign dflt_sec = min_to_sec(cfg.default_min);
	assign sum_up = {1'b0, cur.set_time} + {1'b0, step_sec};
	assign floor_dn = step_sec + MIN_SET_SEC;
	assign y_ext = {4'd0, req.touch_y};
	assign set_min = (req.minutes > {1'b0, cfg.max_min}) ? cfg.max_min : req.minutes[6:0];

	always_comb begin
		nxt = cur;
		expired = 1'b0;
		unique case (req.req_type)
			REQ_TICK: begin
				if (cur.is_running) begin
					if (cur.time_left <= 13'd1) begin
						nxt.is_running = 1'b0;
						nxt.time_left = cur.set_time;
						nxt.alarm_on = 1'b1;
						expired = 1'b1;
					end else begin
						nxt.time_left = cur.time_left - 13'd1;
					end
				end
			end
			REQ_TOUCH: begin
				priority if (cur.is_running) begin
					nxt.is_running = 1'b0;
				end else if (y_ext < ZONE_UPPER_END) begin
					nxt.set_time = (sum_up > {1'b0, max_sec}) ? max_sec : sum_up[12:0];
					nxt.time_left = nxt.set_time;
				end else if (y_ext > ZONE_LOWER_START) begin
					nxt.set_time = (cur.set_time < floor_dn) ? MIN_SET_SEC
						: cur.set_time - step_sec;
					nxt.time_left = nxt.set_time;
				end else begin
					nxt.is_running = 1'b1;
				end
			end
			REQ_SET_MIN: begin
				if (req.minutes == '0) begin
					nxt.is_running = 1'b0;
					nxt.set_time = dflt_sec;
					nxt.time_left = dflt_sec;
				end else begin
					nxt.set_time = min_to_sec(set_min);
					nxt.time_left = nxt.set_time;
				end
			end
			REQ_RUN: nxt.is_running = req.run_flag;
			REQ_DISMISS: nxt.alarm_on = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		res.remaining_seconds = nxt.time_left;
		res.set_seconds = nxt.set_time;
		res.running = nxt.is_running;
		res.paused = !nxt.is_running && (nxt.time_left < nxt.set_time);
		res.expired = expired;
		res.alarm = nxt.alarm_on;
	end

endmodule

// ===== design/touch_zone_countdown_timer_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_data  (in_t)
// out      output     out_valid/out_stall  out_data (out_t)
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One beat per cycle sustained while out does not stall; a beat passes through the input
// register, then the result register behind the next-state logic.
// The timer state updates in the same edge that loads the result register.
// arst_n clears the timer to the reset set time (25 min), stopped, no alarm.
// A stall on out holds the result register; in stalls only when the input
// register is full and cannot move on, so one waiting result never blocks a new beat.

module touch_zone_countdown_timer_top
	import tzct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_t out_data,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	cfg_t cfg;
	state_t state_q;
	state_t state_nxt;
	out_t res_nxt;

	// input register
	logic vld_s1;
	in_t in_s1;

	// result register
	logic out_valid_q;
	out_t out_q;

	// s1 moves into the result register when that one is empty or draining
	logic adv;

	tzct_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data (cfg_data),
		.cfg (cfg)
	);

	tzct_next u_next (
		.cur (state_q),
		.req (in_s1),
		.cfg (cfg),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	assign adv = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	// timer state commits when its beat reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.set_time <= SET_SEC_RST;
			state_q.time_left <= SET_SEC_RST;
			state_q.is_running <= 1'b0;
			state_q.alarm_on <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`TZCT_ASSERT_ALWAYS(a_stall_needs_full_s1, !in_stall || vld_s1,
		"input stalled with empty input register")
	`TZCT_ASSERT_ALWAYS(a_set_range,
		state_q.set_time >= MIN_SET_SEC && state_q.set_time <= MAX_SET_SEC,
		"set time out of range")
	`TZCT_ASSERT_ALWAYS(a_left_range,
		state_q.time_left != '0 && state_q.time_left <= state_q.set_time,
		"remaining time outside 1..set time")
	`TZCT_ASSERT_NEXT(a_expire_alarm, adv && res_nxt.expired,
		state_q.alarm_on && !state_q.is_running && out_valid_q,
		"expiry did not stop the timer and raise the alarm")

endmodule
